[hw/rtl/ise_pkg.sv]
// shared types, constants and helpers for the interpolative set encoder
package ise_pkg;

    localparam int MAX_MEMBERS_DEF = 32;
    localparam int STACK_DEPTH_DEF = 6;
    localparam int WORD_W          = 64;
    localparam int FILL_W          = 7;
    localparam int PADDR_W         = 5;

    typedef enum logic [1:0] {
        REG_RANGE_LOW  = 2'd0,
        REG_RANGE_HIGH = 2'd1,
        REG_START_BIT  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] member;
        logic        final_member;
    } in_item_t;

    typedef struct packed {
        logic [63:0] stream_word;
        logic [6:0]  word_bits;
        logic        last_word;
        logic        set_error;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start_walk;
        logic walk_emit;
        logic pop;
        logic calc;
        logic len;
        logic pack;
        logic fin_held;
        logic fin_pend;
        logic err_out;
        logic clear;
    } ise_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err_seen;
        logic out_free;
        logic overflow;
        logic last_node;
        logic held_valid;
        logic need_pend;
    } ise_sts_t;

    // number of significant bits in a 64-bit value
    function automatic logic [6:0] bit_len64(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[hw/rtl/ise_ctrl.sv]
// sequencer for collection, stack walk, final flush and error reporting
module ise_ctrl
    import ise_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_final,
    input  ise_sts_t sts,
    output ise_cmd_t cmd,
    output logic     in_stall
);

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_CHECK,
        ST_POP,
        ST_CALC,
        ST_LEN,
        ST_PACK,
        ST_FIN_HELD,
        ST_FIN_PEND,
        ST_ERR
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    assign in_stall = (state_reg != ST_COLLECT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_final)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sts.err_seen)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    cmd.start_walk = 1'b1;
                    cmd.walk_emit  = 1'b0;
                    pass_next      = 1'b0;
                    state_next     = ST_POP;
                end
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.len    = 1'b1;
                state_next = ST_PACK;
            end
            ST_PACK:
            begin
                if (!pass_reg || sts.out_free)
                begin
                    cmd.pack = 1'b1;
                    if (sts.overflow)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (sts.last_node)
                    begin
                        if (!pass_reg)
                        begin
                            cmd.start_walk = 1'b1;
                            cmd.walk_emit  = 1'b1;
                            pass_next      = 1'b1;
                            state_next     = ST_POP;
                        end
                        else
                        begin
                            state_next = ST_FIN_HELD;
                        end
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_FIN_HELD:
            begin
                if (!sts.held_valid)
                begin
                    state_next = ST_FIN_PEND;
                end
                else if (sts.out_free)
                begin
                    cmd.fin_held = 1'b1;
                    state_next   = ST_FIN_PEND;
                end
            end
            ST_FIN_PEND:
            begin
                if (!sts.need_pend)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_COLLECT;
                end
                else if (sts.out_free)
                begin
                    cmd.fin_pend = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_COLLECT;
                end
            end
            ST_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.err_out = 1'b1;
                    cmd.clear   = 1'b1;
                    state_next  = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

[hw/rtl/ise_dpath.sv]
// member store, node stack, code arithmetic, bit packer and output register
module ise_dpath
    import ise_pkg::*;
#(
    parameter int MAX_MEMBERS = MAX_MEMBERS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ise_cmd_t    cmd,
    output ise_sts_t    sts,
    input  in_item_t    in_data,
    input  logic [63:0] range_low,
    input  logic [63:0] range_high,
    input  logic [5:0]  start_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    localparam int CW  = $clog2(MAX_MEMBERS + 1);
    localparam int IW  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int SW  = $clog2(STACK_DEPTH + 1);
    localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // collection state
    logic [CW-1:0] count_reg;
    logic [63:0]   prev_reg;
    logic          err_reg;
    logic [63:0]   store_mem [MAX_MEMBERS];

    // node stack
    logic [63:0]   stk_lo    [STACK_DEPTH];
    logic [63:0]   stk_hi    [STACK_DEPTH];
    logic [CW-1:0] stk_first [STACK_DEPTH];
    logic [CW-1:0] stk_n     [STACK_DEPTH];
    logic [SW-1:0] depth_reg;

    // current node
    logic [63:0]   node_lo_reg, node_hi_reg;
    logic [CW-1:0] node_first_reg, node_n_reg;
    logic [63:0]   rd_reg, v_reg, code_reg, diff_reg;
    logic [6:0]    len_reg;

    // packer
    logic [63:0]   word_reg, held_reg;
    logic [6:0]    fill_reg;
    logic          held_valid_reg, emit_reg;

    logic          out_valid_reg;
    out_item_t     out_reg;

    logic          in_bad;
    logic [SIW-1:0] top_idx;
    logic [CW-1:0] top_first, top_n, rd_idx;
    logic [CW-1:0] left, right;
    logic [63:0]   lmin, lmax;
    logic          has_r, has_l;
    logic [SW-1:0] depth_l;
    logic [63:0]   word_or;
    logic [7:0]    fill_sum;
    logic          full;
    logic          out_free;
    logic          out_load;

    assign in_bad = (in_data.member < range_low) || (in_data.member > range_high) ||
                    (range_low > range_high) ||
                    ((count_reg != '0) && (in_data.member <= prev_reg)) ||
                    (count_reg >= CW'(MAX_MEMBERS));

    assign top_idx   = SIW'(depth_reg - SW'(1));
    assign top_first = stk_first[top_idx];
    assign top_n     = stk_n[top_idx];
    assign rd_idx    = top_first + (top_n >> 1);

    assign left    = node_n_reg >> 1;
    assign right   = node_n_reg - left - CW'(1);
    assign lmin    = node_lo_reg + 64'(left);
    assign lmax    = node_hi_reg - 64'(right);
    assign has_r   = (right != '0);
    assign has_l   = (left != '0);
    assign depth_l = depth_reg + SW'(has_r);

    assign word_or  = word_reg | (code_reg << fill_reg[5:0]);
    assign fill_sum = 8'(fill_reg) + 8'(len_reg);
    assign full     = (fill_sum >= 8'd64);

    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = cmd.fin_held || cmd.fin_pend || cmd.err_out ||
                      (cmd.pack && emit_reg && full && held_valid_reg);

    assign sts.err_seen   = err_reg;
    assign sts.out_free   = out_free;
    assign sts.overflow   = (has_r && (depth_reg >= SW'(STACK_DEPTH))) ||
                            (has_l && (depth_l >= SW'(STACK_DEPTH)));
    assign sts.last_node  = (depth_reg == '0) && !has_r && !has_l;
    assign sts.held_valid = held_valid_reg;
    assign sts.need_pend  = (fill_reg != '0) || !held_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // member store, node stack contents and current node arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < CW'(MAX_MEMBERS)))
        begin
            store_mem[count_reg[IW-1:0]] <= in_data.member;
        end
        if (cmd.pop)
        begin
            rd_reg <= store_mem[rd_idx[IW-1:0]];
        end
        if (cmd.start_walk)
        begin
            stk_lo[0]    <= range_low;
            stk_hi[0]    <= range_high;
            stk_first[0] <= '0;
            stk_n[0]     <= count_reg;
        end
        if (cmd.pack && !sts.overflow)
        begin
            if (has_r)
            begin
                stk_lo[depth_reg[SIW-1:0]]    <= v_reg + 64'd1;
                stk_hi[depth_reg[SIW-1:0]]    <= node_hi_reg;
                stk_first[depth_reg[SIW-1:0]] <= node_first_reg + left + CW'(1);
                stk_n[depth_reg[SIW-1:0]]     <= right;
            end
            if (has_l)
            begin
                stk_lo[depth_l[SIW-1:0]]    <= node_lo_reg;
                stk_hi[depth_l[SIW-1:0]]    <= v_reg - 64'd1;
                stk_first[depth_l[SIW-1:0]] <= node_first_reg;
                stk_n[depth_l[SIW-1:0]]     <= left;
            end
        end
        if (cmd.pop)
        begin
            node_lo_reg    <= stk_lo[top_idx];
            node_hi_reg    <= stk_hi[top_idx];
            node_first_reg <= top_first;
            node_n_reg     <= top_n;
        end
        if (cmd.calc)
        begin
            v_reg    <= rd_reg;
            code_reg <= rd_reg - lmin;
            diff_reg <= lmax - lmin;
        end
        if (cmd.len)
        begin
            len_reg <= bit_len64(diff_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prev_reg       <= '0;
            err_reg        <= 1'b0;
            depth_reg      <= '0;
            word_reg       <= '0;
            fill_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            emit_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                prev_reg <= in_data.member;
                if (in_bad)
                begin
                    err_reg <= 1'b1;
                end
                if (count_reg < CW'(MAX_MEMBERS))
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.start_walk)
            begin
                depth_reg      <= SW'(1);
                word_reg       <= '0;
                fill_reg       <= 7'(start_bit);
                held_valid_reg <= 1'b0;
                emit_reg       <= cmd.walk_emit;
            end
            if (cmd.pop)
            begin
                depth_reg <= depth_reg - SW'(1);
            end
            if (cmd.pack)
            begin
                // the restart of the walk owns the depth on the last node
                if (!cmd.start_walk)
                begin
                    depth_reg <= depth_l + SW'(has_l);
                end
                if (emit_reg)
                begin
                    if (full)
                    begin
                        held_reg       <= word_or;
                        held_valid_reg <= 1'b1;
                        word_reg       <= (fill_reg == '0) ? 64'd0 :
                                          (code_reg >> (7'd64 - fill_reg));
                        fill_reg       <= 7'(fill_sum - 8'd64);
                        if (held_valid_reg)
                        begin
                            out_reg <= '{held_reg, 7'd64, 1'b0, 1'b0};
                        end
                    end
                    else
                    begin
                        word_reg <= word_or;
                        fill_reg <= fill_sum[6:0];
                    end
                end
            end
            if (cmd.fin_held)
            begin
                out_reg <= '{held_reg, 7'd64, (fill_reg == '0), 1'b0};
            end
            if (cmd.fin_pend)
            begin
                out_reg <= '{word_reg, fill_reg, 1'b1, 1'b0};
            end
            if (cmd.err_out)
            begin
                out_reg <= '{64'd0, 7'd0, 1'b1, 1'b1};
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                prev_reg  <= '0;
                err_reg   <= 1'b0;
                depth_reg <= '0;
                word_reg  <= '0;
                fill_reg  <= '0;
            end
        end
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= SW'(STACK_DEPTH))
        else $error("node stack deeper than its storage");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < 7'd64)
        else $error("pending fill reached a full word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_MEMBERS))
        else $error("member count past store size");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> !(out_valid_reg && $changed(out_reg)))
        else $error("stalled result overwritten");

endmodule

[hw/rtl/interpolative_set_encoder_core.sv]
// top level of the interpolative set encoder: register port, controller, datapath
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid / in_stall   | member, final_member
//  out      | output    | out_valid / out_stall | stream_word, word_bits,
//           |           |                       | last_word, set_error
//  config   | input     | apb psel/penable      | range_low, range_high, start_bit
//
// members load one per cycle; the final member is followed by an error check step
// coding walks the node stack twice (a depth check, then the real pass), each
// pass taking every member through the pop, calc, len and pack steps, and then
// the flush steps send the held and pending words before the next accepted transaction
// the walk shares one memory read port and one pack unit per node
// a stalled output holds the real pass at a pack step and the flush and error steps
// reset clears control state; the member store needs no clearing
module interpolative_set_encoder_core
    import ise_pkg::*;
#(
    parameter int MAX_MEMBERS = MAX_MEMBERS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input transaction
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    // output transaction
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [63:0] range_low_reg;
    logic [63:0] range_high_reg;
    logic [5:0]  start_bit_reg;
    reg_idx_t    reg_sel;
    logic        wr_en;
    ise_cmd_t    cmd;
    ise_sts_t    sts;

    // registers sit on 8-byte boundaries
    assign reg_sel = reg_idx_t'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= '1;
            start_bit_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_RANGE_LOW:  range_low_reg  <= pwdata;
                REG_RANGE_HIGH: range_high_reg <= pwdata;
                REG_START_BIT:  start_bit_reg  <= pwdata[5:0];
                default:        ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_RANGE_LOW:  prdata = range_low_reg;
            REG_RANGE_HIGH: prdata = range_high_reg;
            REG_START_BIT:  prdata = 64'(start_bit_reg);
            default:        prdata = '0;
        endcase
    end

    // sequencer
    ise_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_final (in_data.final_member),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // store, stack, packer and output register
    ise_dpath #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_data    (in_data),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .start_bit  (start_bit_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
